// ===== hdl/wmrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmrs_pkg
// Shared types, codes and helpers of the write multiple registers server.
// ----------------------------------------------------------------------------
package wmrs_pkg;

  // Input operations.
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_PULL   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REFUSE = 2'd3;

  localparam logic [7:0] FUNC_CODE  = 8'h10;
  localparam logic [7:0] EXC_FLAG   = 8'h80;
  localparam logic [7:0] HEADER_LEN = 8'd6;
  localparam logic [7:0] ECHO_LEN   = 8'd5;
  localparam logic [7:0] EXC_ROOM   = 8'd2;

  // Exception codes.
  localparam logic [7:0] EXC_NONE     = 8'd0;
  localparam logic [7:0] EXC_ADDRESS  = 8'd2;
  localparam logic [7:0] EXC_VALUE    = 8'd3;
  localparam logic [7:0] EXC_DEV_FAIL = 8'd4;
  localparam logic [7:0] EXC_BUSY     = 8'd6;

  // What the result emitter has to send for one processed item.
  typedef enum logic [2:0] {
    J_WRITE,
    J_ACCEPT,
    J_REFUSE,
    J_EXC,
    J_ECHO
  } jkind_t;

  typedef struct packed {
    jkind_t      jk;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [7:0]  code;
    logic        wl;
  } job_t;

  typedef struct packed {
    logic free;
  } emit_stat_t;

  function automatic logic [2:0] job_len(input jkind_t jk);
    logic [2:0] n;
    unique case (jk)
      J_EXC:   n = 3'd2;
      J_ECHO:  n = 3'd5;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Status codes the store may return unchanged; anything else is a device failure.
  function automatic logic [7:0] normalize(input logic [7:0] e);
    logic [7:0] r;
    if (e == EXC_NONE || e == EXC_ADDRESS || e == EXC_VALUE ||
        e == EXC_DEV_FAIL || e == EXC_BUSY) begin
      r = e;
    end else begin
      r = EXC_DEV_FAIL;
    end
    return r;
  endfunction

  function automatic job_t make_exc(input logic [7:0] code, input logic [7:0] room);
    job_t j;
    j = '0;
    if (room < EXC_ROOM) begin
      j.jk = J_REFUSE;
    end else begin
      j.jk   = J_EXC;
      j.code = code;
    end
    return j;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wmrs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wmrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 123
) (
  input  wire logic                                     clk,
  input  wire logic                                     wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic                                     rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/wmrs_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmrs_emit
// Holds the results of one processed item and sends them out one after another.
// ----------------------------------------------------------------------------
module wmrs_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire wmrs_pkg::job_t job,
  input  wire logic [15:0]    rd_data,
  output wmrs_pkg::emit_stat_t stat,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          kind,
  output logic [15:0]         reg_address,
  output logic [15:0]         reg_value,
  output logic                write_last,
  output logic [7:0]          resp_byte,
  output logic                resp_last,
  output logic [6:0]          accepted_count
);

  wmrs_pkg::job_t job_q;
  logic           jvalid;
  logic [2:0]     idx;
  logic           last_res;
  logic           out_fire;
  logic           finishing;

  assign out_valid = jvalid;
  assign out_fire  = jvalid && !out_stall;
  assign last_res  = (idx == wmrs_pkg::job_len(job_q.jk) - 3'd1);
  assign finishing = out_fire && last_res;
  assign stat.free = !jvalid || finishing;

  always_ff @(posedge clk) begin
    if (rst) begin
      jvalid <= 1'b0;
      idx    <= 3'd0;
    end else if (load) begin
      jvalid <= 1'b1;
      job_q  <= job;
      idx    <= 3'd0;
    end else if (finishing) begin
      jvalid <= 1'b0;
    end else if (out_fire) begin
      idx <= idx + 3'd1;
    end
  end

  always_comb begin
    kind           = wmrs_pkg::KIND_WRITE;
    reg_address    = 16'd0;
    reg_value      = 16'd0;
    write_last     = 1'b0;
    resp_byte      = 8'd0;
    resp_last      = 1'b0;
    accepted_count = 7'd0;
    unique case (job_q.jk)
      wmrs_pkg::J_WRITE: begin
        reg_address = job_q.addr;
        reg_value   = rd_data;
        write_last  = job_q.wl;
      end
      wmrs_pkg::J_ACCEPT: begin
        kind           = wmrs_pkg::KIND_ACCEPT;
        accepted_count = job_q.qty[6:0];
      end
      wmrs_pkg::J_EXC: begin
        kind      = wmrs_pkg::KIND_RESP;
        resp_last = last_res;
        resp_byte = last_res ? job_q.code : (wmrs_pkg::FUNC_CODE | wmrs_pkg::EXC_FLAG);
      end
      wmrs_pkg::J_ECHO: begin
        kind      = wmrs_pkg::KIND_RESP;
        resp_last = last_res;
        unique case (idx)
          3'd0:    resp_byte = wmrs_pkg::FUNC_CODE;
          3'd1:    resp_byte = job_q.addr[15:8];
          3'd2:    resp_byte = job_q.addr[7:0];
          3'd3:    resp_byte = job_q.qty[15:8];
          default: resp_byte = job_q.qty[7:0];
        endcase
      end
      default: begin
        kind = wmrs_pkg::KIND_REFUSE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/write_multiple_registers_server.sv =====
`default_nettype none
// Flow: an item is taken into a holding register and processed from there once the
// result emitter is free; its first result is registered in the emitter and then
// shown on the output. Throughput: one item per cycle while each item gives at most
// one result and the output is not stalled; an item with several results (exception,
// echo) keeps the next item waiting until the last of its results has been taken.
// Reset: synchronous; clears control state, response_room returns to 255, and the
// value buffer RAM keeps undefined contents until a request writes it.
// ----------------------------------------------------------------------------
// write_multiple_registers_server
// Modbus write multiple registers server: parses the request, issues the register
// writes from a buffer RAM and sends the exception or the echo response.
// ----------------------------------------------------------------------------
module write_multiple_registers_server #(
  parameter int MAX_WRITE_REGS = 123
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  input  wire logic [7:0]  write_status,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [15:0]      reg_address,
  output logic [15:0]      reg_value,
  output logic             write_last,
  output logic [7:0]       resp_byte,
  output logic             resp_last,
  output logic [6:0]       accepted_count
);

  localparam int AW = (MAX_WRITE_REGS > 1) ? $clog2(MAX_WRITE_REGS) : 1;
  localparam logic [AW:0] MAX_IDX = (AW + 1)'(MAX_WRITE_REGS);
  localparam logic [15:0] MAX_Q   = 16'(MAX_WRITE_REGS);
  localparam logic [6:0]  MAX_ROW = 7'(MAX_WRITE_REGS);

  typedef enum logic [1:0] {PH_RECV, PH_PULL, PH_AWAIT} phase_t;

  phase_t      phase;
  logic [7:0]  response_room;
  logic [7:0]  byte_counter;
  logic [7:0]  function_byte;
  logic [15:0] start_address;
  logic [15:0] register_quantity;
  logic [7:0]  declared_byte_count;
  logic [7:0]  hi_byte;
  logic [AW-1:0] pull_index;

  // Holding register for one accepted item.
  logic        pend_valid;
  logic [1:0]  pend_op;
  logic [7:0]  pend_byte;
  logic        pend_last;
  logic [7:0]  pend_status;

  wmrs_pkg::emit_stat_t emit_stat;
  wmrs_pkg::job_t       job;
  logic                 load;
  logic                 process;
  logic                 in_fire;
  logic                 do_byte;
  logic                 do_pull;
  logic                 do_stat;
  logic                 accept_ok;
  logic                 wl;

  logic [7:0]  cnt_next;
  logic [7:0]  function_byte_next;
  logic [15:0] start_address_next;
  logic [15:0] register_quantity_next;
  logic [7:0]  declared_byte_count_next;
  logic [7:0]  data_pos;
  logic [6:0]  row;
  logic        ram_we;
  logic        bad_hdr;
  logic        bad_qty;
  logic        bad_addr;
  logic [7:0]  stat_code;
  logic [15:0] rd_data;

  assign process  = pend_valid && emit_stat.free;
  assign in_stall = pend_valid && !process;
  assign in_fire  = in_valid && !in_stall;

  assign do_byte = process && pend_op == wmrs_pkg::OP_BYTE && phase == PH_RECV;
  assign do_pull = process && pend_op == wmrs_pkg::OP_PULL && phase == PH_PULL &&
                   ({1'b0, pull_index} < MAX_IDX);
  assign do_stat = process && pend_op == wmrs_pkg::OP_STATUS && phase == PH_AWAIT;

  assign data_pos = byte_counter - wmrs_pkg::HEADER_LEN;
  assign row      = data_pos[7:1];
  // The high byte of a value is held until its low byte arrives; then the word is stored.
  assign ram_we   = do_byte && byte_counter >= wmrs_pkg::HEADER_LEN && data_pos[0] &&
                    row < MAX_ROW;
  assign cnt_next = (byte_counter == 8'hFF) ? byte_counter : byte_counter + 8'd1;
  assign wl       = (16'(pull_index) + 16'd1) >= register_quantity;
  assign stat_code = wmrs_pkg::normalize(pend_status);

  // Header fields as they stand after the current byte.
  always_comb begin
    function_byte_next       = function_byte;
    start_address_next       = start_address;
    register_quantity_next   = register_quantity;
    declared_byte_count_next = declared_byte_count;
    unique case (byte_counter)
      8'd0:    function_byte_next             = pend_byte;
      8'd1:    start_address_next[15:8]       = pend_byte;
      8'd2:    start_address_next[7:0]        = pend_byte;
      8'd3:    register_quantity_next[15:8]   = pend_byte;
      8'd4:    register_quantity_next[7:0]    = pend_byte;
      8'd5:    declared_byte_count_next       = pend_byte;
      default: ;
    endcase
  end

  always_comb begin
    bad_hdr  = cnt_next < wmrs_pkg::HEADER_LEN || function_byte_next != wmrs_pkg::FUNC_CODE;
    bad_qty  = register_quantity_next == 16'd0 || register_quantity_next > MAX_Q ||
               {8'h00, declared_byte_count_next} != {register_quantity_next[14:0], 1'b0} ||
               {1'b0, cnt_next} != ({1'b0, wmrs_pkg::HEADER_LEN} +
                                    {1'b0, declared_byte_count_next});
    bad_addr = ({1'b0, start_address_next} + {1'b0, register_quantity_next}) > 17'h10000;
  end

  always_comb begin
    job       = '0;
    load      = 1'b0;
    accept_ok = 1'b0;
    if (do_byte && pend_last) begin
      load = 1'b1;
      priority if (bad_hdr || bad_qty) begin
        job = wmrs_pkg::make_exc(wmrs_pkg::EXC_VALUE, response_room);
      end else if (bad_addr) begin
        job = wmrs_pkg::make_exc(wmrs_pkg::EXC_ADDRESS, response_room);
      end else if (response_room < wmrs_pkg::ECHO_LEN) begin
        job.jk = wmrs_pkg::J_REFUSE;
      end else begin
        job.jk    = wmrs_pkg::J_ACCEPT;
        job.qty   = register_quantity_next;
        accept_ok = 1'b1;
      end
    end else if (do_pull) begin
      load     = 1'b1;
      job.jk   = wmrs_pkg::J_WRITE;
      job.addr = start_address + 16'(pull_index);
      job.wl   = wl;
    end else if (do_stat) begin
      load = 1'b1;
      if (stat_code != wmrs_pkg::EXC_NONE) begin
        job = wmrs_pkg::make_exc(stat_code, response_room);
      end else begin
        job.jk   = wmrs_pkg::J_ECHO;
        job.addr = start_address;
        job.qty  = register_quantity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_RECV;
      response_room       <= 8'd255;
      byte_counter        <= 8'd0;
      function_byte       <= 8'd0;
      start_address       <= 16'd0;
      register_quantity   <= 16'd0;
      declared_byte_count <= 8'd0;
      pull_index          <= '0;
      pend_valid          <= 1'b0;
    end else begin
      if (cfg_wen) begin
        response_room <= cfg_wdata;
      end
      if (in_fire) begin
        pend_valid  <= 1'b1;
        pend_op     <= op;
        pend_byte   <= in_byte;
        pend_last   <= in_last;
        pend_status <= write_status;
      end else if (process) begin
        pend_valid <= 1'b0;
      end
      if (do_byte) begin
        function_byte       <= function_byte_next;
        start_address       <= start_address_next;
        register_quantity   <= register_quantity_next;
        declared_byte_count <= declared_byte_count_next;
        if (!data_pos[0]) begin
          hi_byte <= pend_byte;
        end
        byte_counter <= pend_last ? 8'd0 : cnt_next;
        if (accept_ok) begin
          phase      <= PH_PULL;
          pull_index <= '0;
        end
      end
      if (do_pull) begin
        if (wl) begin
          phase <= PH_AWAIT;
        end else begin
          pull_index <= pull_index + 1'b1;
        end
      end
      if (do_stat) begin
        phase <= PH_RECV;
      end
    end
  end

  wmrs_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WRITE_REGS)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (row[AW-1:0]),
    .wr_data ({hi_byte, pend_byte}),
    .rd_en   (do_pull),
    .rd_addr (pull_index),
    .rd_data (rd_data)
  );

  wmrs_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .job            (job),
    .rd_data        (rd_data),
    .stat           (emit_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .reg_address    (reg_address),
    .reg_value      (reg_value),
    .write_last     (write_last),
    .resp_byte      (resp_byte),
    .resp_last      (resp_last),
    .accepted_count (accepted_count)
  );

endmodule
`default_nettype wire

// ===== hdl/wmrs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wmrs_checker
// Port-level assertions for the write multiple registers server.
// ----------------------------------------------------------------------------
module wmrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [15:0] reg_address,
  input wire logic [15:0] reg_value,
  input wire logic        write_last,
  input wire logic [7:0]  resp_byte,
  input wire logic        resp_last,
  input wire logic [6:0]  accepted_count
);

  // A stalled result item holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(reg_address) &&
    $stable(reg_value) && $stable(resp_byte) && $stable(resp_last))
    else $error("stalled result item changed");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wmrs_pkg::KIND_WRITE |->
    reg_address == 16'd0 && reg_value == 16'd0 && !write_last)
    else $error("write fields set on a non-write item");

  a_resp_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && resp_last |-> kind == wmrs_pkg::KIND_RESP)
    else $error("resp_last on a non-response item");

  a_accept_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == wmrs_pkg::KIND_ACCEPT |-> accepted_count != 7'd0)
    else $error("accepted request with zero quantity");

endmodule

bind write_multiple_registers_server wmrs_checker u_wmrs_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .reg_address    (reg_address),
  .reg_value      (reg_value),
  .write_last     (write_last),
  .resp_byte      (resp_byte),
  .resp_last      (resp_last),
  .accepted_count (accepted_count)
);
`default_nettype wire

// ===== sim/tb_write_multiple_registers_server.sv =====
// ----------------------------------------------------------------------------
// tb_write_multiple_registers_server
// Self-checking bench for the Modbus write multiple registers server. Request
// PDUs, register write pulls and store status codes are driven through the
// valid/stall input port, and a scoreboard predicts every register write,
// acceptance, refusal, exception and echo byte that the block should produce.
// ----------------------------------------------------------------------------
module tb_write_multiple_registers_server;
  import wmrs_pkg::*;

  localparam int MAX_REGS = 123;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int RUN_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 8;
  localparam int HOLD_CYCLES = 150;

  typedef enum logic [1:0] {RECEIVING, PULLING, AWAITING_STATUS} srv_phase_t;

  typedef enum int {
    REQ_GOOD, REQ_SHORT, REQ_BAD_FUNC, REQ_ZERO_QTY, REQ_BIG_QTY,
    REQ_BAD_COUNT, REQ_BAD_LEN, REQ_ADDR_WRAP, REQ_NOISE, REQ_LONG
  } req_shape_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic        write_last;
    logic [7:0]  resp_byte;
    logic        resp_last;
    logic [6:0]  accepted_count;
  } server_result_t;

  class write_regs_scoreboard;
    logic [7:0]     room;
    logic [7:0]     byte_cnt;
    logic [7:0]     func;
    logic [15:0]    start_addr;
    logic [15:0]    qty;
    logic [7:0]     decl_count;
    logic [15:0]    vbuf [MAX_REGS];
    logic [6:0]     pull_idx;
    srv_phase_t     phase;
    server_result_t awaited_results[$];
    int             mismatches;

    function new();
      room = 8'hFF;
      byte_cnt = '0;
      func = '0;
      start_addr = '0;
      qty = '0;
      decl_count = '0;
      foreach (vbuf[i]) vbuf[i] = '0;
      pull_idx = '0;
      phase = RECEIVING;
      mismatches = 0;
    endfunction

    function void push_result(logic [1:0] k, logic [15:0] a, logic [15:0] v, logic wl,
                              logic [7:0] rb, logic rl, logic [6:0] ac);
      server_result_t r;
      r = '{k, a, v, wl, rb, rl, ac};
      awaited_results.push_back(r);
    endfunction

    // With too little room for even the two exception bytes, the request is refused.
    function void push_exception(logic [7:0] code);
      if (room < EXC_ROOM) begin
        push_result(KIND_REFUSE, '0, '0, 1'b0, '0, 1'b0, '0);
      end else begin
        push_result(KIND_RESP, '0, '0, 1'b0, FUNC_CODE | EXC_FLAG, 1'b0, '0);
        push_result(KIND_RESP, '0, '0, 1'b0, code, 1'b1, '0);
      end
    endfunction

    function void close_request();
      int len;
      int q;
      len = byte_cnt;
      q = qty;
      byte_cnt = '0;
      if (len < HEADER_LEN || func != FUNC_CODE) begin
        push_exception(EXC_VALUE);
      end else if (q == 0 || q > MAX_REGS || int'(decl_count) != ((q * 2) & 'hFFFF) ||
                   len != int'(HEADER_LEN) + int'(decl_count)) begin
        push_exception(EXC_VALUE);
      end else if (int'(start_addr) + q - 1 > 'hFFFF) begin
        push_exception(EXC_ADDRESS);
      end else if (room < ECHO_LEN) begin
        push_result(KIND_REFUSE, '0, '0, 1'b0, '0, 1'b0, '0);
      end else begin
        pull_idx = '0;
        phase = PULLING;
        push_result(KIND_ACCEPT, '0, '0, 1'b0, '0, 1'b0, 7'(q));
      end
    endfunction

    function void note_item(logic [1:0] o, logic [7:0] b, logic l, logic [7:0] s);
      int d;
      logic [7:0] code;
      logic wl;
      case (o)
        OP_BYTE: begin
          if (phase == RECEIVING) begin
            case (byte_cnt)
              8'd0: func = b;
              8'd1: start_addr[15:8] = b;
              8'd2: start_addr[7:0] = b;
              8'd3: qty[15:8] = b;
              8'd4: qty[7:0] = b;
              8'd5: decl_count = b;
              default: begin
                // Data bytes past the end of the buffer are dropped.
                d = int'(byte_cnt) - int'(HEADER_LEN);
                if ((d >> 1) < MAX_REGS) begin
                  if (d[0] == 1'b0) vbuf[d >> 1][15:8] = b;
                  else vbuf[d >> 1][7:0] = b;
                end
              end
            endcase
            if (byte_cnt != 8'hFF) byte_cnt++;
            if (l) close_request();
          end
        end
        OP_PULL: begin
          if (phase == PULLING && pull_idx < MAX_REGS) begin
            wl = (int'(pull_idx) + 1 >= int'(qty));
            push_result(KIND_WRITE, start_addr + 16'(pull_idx), vbuf[pull_idx], wl,
                        '0, 1'b0, '0);
            if (wl) phase = AWAITING_STATUS;
            else pull_idx++;
          end
        end
        OP_STATUS: begin
          if (phase == AWAITING_STATUS) begin
            phase = RECEIVING;
            // Codes the store is not allowed to return become a device failure.
            if (s inside {EXC_NONE, EXC_ADDRESS, EXC_VALUE, EXC_DEV_FAIL, EXC_BUSY})
              code = s;
            else
              code = EXC_DEV_FAIL;
            if (code != EXC_NONE) begin
              push_exception(code);
            end else begin
              push_result(KIND_RESP, '0, '0, 1'b0, FUNC_CODE, 1'b0, '0);
              push_result(KIND_RESP, '0, '0, 1'b0, start_addr[15:8], 1'b0, '0);
              push_result(KIND_RESP, '0, '0, 1'b0, start_addr[7:0], 1'b0, '0);
              push_result(KIND_RESP, '0, '0, 1'b0, qty[15:8], 1'b0, '0);
              push_result(KIND_RESP, '0, '0, 1'b0, qty[7:0], 1'b1, '0);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(server_result_t got);
      server_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", got.kind);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("reg_address", want.reg_address, got.reg_address);
      check_field("reg_value", want.reg_value, got.reg_value);
      check_field("write_last", want.write_last, got.write_last);
      check_field("resp_byte", want.resp_byte, got.resp_byte);
      check_field("resp_last", want.resp_last, got.resp_last);
      check_field("accepted_count", want.accepted_count, got.accepted_count);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_BYTE;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic [7:0]  write_status = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [15:0] reg_address;
  logic [15:0] reg_value;
  logic        write_last;
  logic [7:0]  resp_byte;
  logic        resp_last;
  logic [6:0]  accepted_count;

  write_regs_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int useful_items = 0;

  write_multiple_registers_server #(
    .MAX_WRITE_REGS(MAX_REGS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .in_byte(in_byte),
    .in_last(in_last),
    .write_status(write_status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .reg_address(reg_address),
    .reg_value(reg_value),
    .write_last(write_last),
    .resp_byte(resp_byte),
    .resp_last(resp_last),
    .accepted_count(accepted_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("write_multiple_registers_server regression: fail");
    $finish;
  end

  // Receiver side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{kind, reg_address, reg_value, write_last, resp_byte, resp_last,
                        accepted_count});
  end

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic offer(input logic [1:0] o, input logic [7:0] b, input logic l,
                       input logic [7:0] s);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    op <= o;
    in_byte <= b;
    in_last <= l;
    write_status <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(o, b, l, s);
  endtask

  task automatic offer_op(input logic [1:0] o, input logic [7:0] s);
    offer(o, 8'($urandom), 1'($urandom), s);
  endtask

  task automatic offer_stray();
    logic [1:0] live;
    logic [1:0] o;
    case (sb.phase)
      RECEIVING: live = OP_BYTE;
      PULLING:   live = OP_PULL;
      default:   live = OP_STATUS;
    endcase
    do o = 2'($urandom); while (o == live);
    offer_op(o, 8'($urandom));
  endtask

  task automatic send_pdu(input logic [7:0] pdu[$]);
    foreach (pdu[i]) offer(OP_BYTE, pdu[i], i == pdu.size() - 1, 8'($urandom));
  endtask

  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_room(input logic [7:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.room = v;
    @(posedge clk);
  endtask

  task automatic run_transaction(input req_shape_t shape, input int nregs, input bit hold);
    logic [7:0] pdu[$];
    logic [7:0] fn;
    logic [7:0] code;
    int q;
    int addr;
    int qfield;
    int bc;
    int ndata;
    q = nregs;
    if (shape == REQ_ADDR_WRAP && q < 2) q = 2;
    fn = FUNC_CODE;
    // A quarter of the requests end exactly on the last register address.
    addr = ($urandom_range(3) == 0) ? 65536 - q : $urandom_range(65536 - q);
    qfield = q;
    bc = 2 * q;
    ndata = 2 * q;
    case (shape)
      REQ_BAD_FUNC: do fn = 8'($urandom); while (fn == FUNC_CODE);
      REQ_ZERO_QTY: begin
        qfield = 0;
        bc = 0;
        ndata = 0;
      end
      REQ_BIG_QTY: begin
        qfield = $urandom_range(65535, MAX_REGS + 1);
        bc = $urandom_range(20);
        ndata = bc;
      end
      REQ_BAD_COUNT: begin
        bc = (2 * q) ^ (1 << $urandom_range(3));
        ndata = bc;
      end
      REQ_BAD_LEN: ndata = 2 * q + (($urandom_range(1) == 1) ? 1 : -1);
      REQ_ADDR_WRAP: addr = $urandom_range(65535, 65536 - q + 1);
      REQ_LONG: begin
        qfield = $urandom_range(65535);
        bc = $urandom_range(255);
        ndata = $urandom_range(294, 250);
      end
      default: ;
    endcase
    pdu = {fn, 8'(addr >> 8), 8'(addr), 8'(qfield >> 8), 8'(qfield), 8'(bc)};
    repeat (ndata) pdu.push_back(8'($urandom));
    if (shape == REQ_SHORT || shape == REQ_NOISE) begin
      pdu.delete();
      pdu.push_back(($urandom_range(1) == 1) ? FUNC_CODE : 8'($urandom));
      repeat ((shape == REQ_SHORT) ? $urandom_range(4) : $urandom_range(11))
        pdu.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 10) offer_stray();
    send_pdu(pdu);
    useful_items += pdu.size();
    if (hold && sb.phase == PULLING) hold_request = HOLD_CYCLES;
    while (sb.phase == PULLING) begin
      if ($urandom_range(99) < 8) begin
        offer_stray();
      end else begin
        offer_op(OP_PULL, 8'($urandom));
        useful_items++;
      end
    end
    if (sb.phase == AWAITING_STATUS) begin
      if ($urandom_range(99) < 10) offer_stray();
      case ($urandom_range(9))
        0, 1, 2, 3, 4: code = EXC_NONE;
        5: code = EXC_ADDRESS;
        6: code = EXC_VALUE;
        7: code = ($urandom_range(1) == 1) ? EXC_DEV_FAIL : EXC_BUSY;
        default: code = 8'($urandom);
      endcase
      offer_op(OP_STATUS, code);
      useful_items++;
    end
  endtask

  initial begin
    logic [7:0] pdu[$];
    logic [7:0] room_val;
    req_shape_t shape;
    int budget;
    int nregs;
    int r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_room(8'd255);

    // One register at the top address holding all ones, then a clean echo.
    pdu = {FUNC_CODE, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h02, 8'hFF, 8'hFF};
    send_pdu(pdu);
    offer_op(OP_PULL, 8'($urandom));
    offer_op(OP_STATUS, EXC_NONE);
    // Operations out of phase and the unused operation are ignored.
    offer_op(OP_PULL, 8'($urandom));
    offer_op(OP_STATUS, EXC_NONE);
    offer_op(OP_NONE, 8'($urandom));
    // A request of a single byte is too short.
    pdu.delete();
    pdu.push_back(FUNC_CODE);
    send_pdu(pdu);
    // Zero value at address zero; an unknown store code turns into a device failure.
    pdu = {FUNC_CODE, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00, 8'h00};
    send_pdu(pdu);
    offer_op(OP_BYTE, 8'($urandom));
    offer_op(OP_PULL, 8'($urandom));
    offer_op(OP_STATUS, 8'hFF);
    drain();

    // The receiver holds off while pulls keep coming, so the block backs up.
    run_transaction(REQ_GOOD, 8, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 37 : 0;
      stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 37 : 0;
      drain();
      case (ph)
        0: room_val = 8'd255;
        1: room_val = 8'd5;
        2: room_val = 8'd1;
        4: room_val = 8'd2;
        6: room_val = 8'd0;
        7: room_val = 8'd4;
        default: room_val = 8'($urandom_range(255, 5));
      endcase
      set_room(room_val);
      budget = useful_items + PHASE_ITEMS;
      while (useful_items < budget) begin
        r = $urandom_range(99);
        if (r < 80) nregs = $urandom_range(4, 1);
        else if (r < 97) nregs = $urandom_range(10, 5);
        else nregs = $urandom_range(16, 11);
        if ($urandom_range(99) < 60) shape = REQ_GOOD;
        else shape = req_shape_t'($urandom_range(REQ_NOISE, REQ_SHORT));
        run_transaction(shape, nregs, 1'b0);
      end
    end
    drain();

    if (sb.awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.awaited_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0)
      $display("write_multiple_registers_server regression: pass");
    else
      $display("write_multiple_registers_server regression: fail");
    $finish;
  end

endmodule
